### sv/pwmtca_pkg.sv
// Shared types and constants for the PWM timer channel allocator.
package pwmtca_pkg;

    // Channel bank size and timer count
    localparam int CHANNEL_COUNT = 16;
    localparam int TIMER_COUNT   = 4;
    localparam int CH_IDX_W      = $clog2(CHANNEL_COUNT);
    localparam int TMR_W         = 2;
    localparam int CH_W          = 4;
    localparam int CH_EXT_W      = CH_W + 1;
    localparam int FREQ_W        = 26;
    localparam int CNT_W         = 3;
    localparam int LIMIT_RESET   = 4;

    // Request kinds
    typedef enum logic [1:0] {
        FN_ALLOC   = 2'd0,
        FN_RELEASE = 2'd1,
        FN_RESERVE = 2'd2,
        FN_UNUSED  = 2'd3
    } t_func_e;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE        = 2'd0,
        ST_NO_RESOURCE = 2'd1,
        ST_NOT_BUSY    = 2'd2,
        ST_RSVD        = 2'd3
    } t_status_e;

endpackage

### sv/pwm_timer_channel_allocator.sv
// PWM channel allocator over four shared timers, with a small scan sequencer.
//
// Requests arrive on the slave stream: tuser carries the request kind (allocate,
// release channel, reserve timer), tdata carries frequency, channel and timer.
// Each request gives exactly one result transfer on the master stream: tuser is
// the status, tdata the granted channel and its timer.
// The channels_per_timer limit is written through i_cfg_we / i_cfg_wdata; the user
// must write it only while the block is idle (the block does not enforce this); it resets to four.
// Allocate walks the timers in order with one compare unit: it checks each timer,
// tries the channel slots of a fitting timer one by one, and leaves a timer when
// its slots run out, moving on to the next timer or failing after the last one.
// Release and reserve pass through accept, update and result.
// The block takes one request at a time; tready is high only while the
// sequencer is idle. A finished result waits in the output register, so the
// next request is accepted while the receiver stalls; the sequencer holds the
// following result until the output register frees up.
// Reset (synchronous, active low) clears all timer frequencies, user counts,
// channel busy flags and explicit mode, and empties the output register.
module pwm_timer_channel_allocator
    import pwmtca_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: channels_per_timer
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    // Request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // frequency_hz[25:0], channel_index[29:26],
                                          // timer_index[31:30]
    input  logic [1:0]  i_s_axis_tuser,   // func[1:0]
    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // granted_channel[3:0], granted_timer[5:4],
                                          // zero[7:6]
    output logic [1:0]  o_m_axis_tuser    // status[1:0]
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TIMER,
        S_SLOT,
        S_EXEC,
        S_DONE
    } t_state_e;

    localparam logic [TMR_W-1:0]    TMR_LAST  = TMR_W'(TIMER_COUNT - 1);
    localparam logic [CH_EXT_W-1:0] CH_LIMIT  = CH_EXT_W'(CHANNEL_COUNT);

    t_state_e               r_state;
    logic [CNT_W-1:0]       r_limit;
    logic                   r_explicit;
    logic [FREQ_W-1:0]      r_tf      [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] r_tf_set;
    logic [CNT_W-1:0]       r_cnt     [TIMER_COUNT];
    logic [CHANNEL_COUNT-1:0] r_busy;

    // Captured request
    t_func_e                r_func;
    logic [FREQ_W-1:0]      r_freq;
    logic [CH_W-1:0]        r_chan;
    logic [TMR_W-1:0]       r_tsel;

    // Scan position
    logic [TMR_W-1:0]       r_tmr;
    logic [CNT_W-1:0]       r_slot;

    // Pending result
    t_status_e              r_res_status;
    logic [CH_W-1:0]        r_res_chan;
    logic [TMR_W-1:0]       r_res_tmr;

    // Output register
    logic                   r_out_valid;
    t_status_e              r_out_status;
    logic [CH_W-1:0]        r_out_chan;
    logic [TMR_W-1:0]       r_out_tmr;

    logic                   fits;
    logic                   has_room;
    logic [CH_EXT_W-1:0]    slot_ch;
    logic                   slot_ok;
    logic                   rel_in_range;
    logic [CH_IDX_W-1:0]    rel_idx;
    logic [TMR_W-1:0]       rel_tmr;
    logic [CNT_W-1:0]       rel_cnt;
    logic                   out_load;

    // Compare unit: qualify current timer, locate current slot's channel
    always_comb begin
        fits     = !r_tf_set[r_tmr] || (r_tf[r_tmr] == r_freq);
        has_room = r_cnt[r_tmr] < r_limit;
        slot_ch  = {r_slot[2:1], r_tmr, r_slot[0]};
        slot_ok  = (slot_ch < CH_LIMIT) && !r_busy[slot_ch[CH_IDX_W-1:0]];
        rel_in_range = {1'b0, r_chan} < CH_LIMIT;
        rel_idx  = r_chan[CH_IDX_W-1:0];
        rel_tmr  = r_chan[2:1];
        rel_cnt  = (r_cnt[rel_tmr] != '0) ? r_cnt[rel_tmr] - CNT_W'(1) : '0;
    end

    // Move the pending result into the output register when it is free
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {2'b00, r_out_tmr, r_out_chan};

    // Sequencer, allocation state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= CNT_W'(LIMIT_RESET);
            r_explicit  <= 1'b0;
            r_tf_set    <= '0;
            r_busy      <= '0;
            r_out_valid <= 1'b0;
            for (int t = 0; t < TIMER_COUNT; t++) begin
                r_tf[t]  <= '0;
                r_cnt[t] <= '0;
            end
        end else begin
            // Take configuration writes
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end

            // Load a new result, or drop the old one once the receiver takes it
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_func <= t_func_e'(i_s_axis_tuser);
                        r_freq <= i_s_axis_tdata[25:0];
                        r_chan <= i_s_axis_tdata[29:26];
                        r_tsel <= i_s_axis_tdata[31:30];
                        r_tmr  <= '0;
                        r_state <= (t_func_e'(i_s_axis_tuser) == FN_ALLOC) ? S_TIMER
                                                                           : S_EXEC;
                    end
                end

                S_TIMER: begin
                    if (fits && has_room) begin
                        // Claim an unset frequency before searching the slots
                        if (!r_tf_set[r_tmr]) begin
                            r_tf_set[r_tmr] <= 1'b1;
                            r_tf[r_tmr]     <= r_freq;
                        end
                        r_slot  <= '0;
                        r_state <= S_SLOT;
                    end else if (r_tmr == TMR_LAST) begin
                        r_res_status <= ST_NO_RESOURCE;
                        r_res_chan   <= '0;
                        r_res_tmr    <= '0;
                        r_state      <= S_DONE;
                    end else begin
                        r_tmr <= r_tmr + TMR_W'(1);
                    end
                end

                S_SLOT: begin
                    priority if (r_slot >= r_limit) begin
                        // Timer exhausted: move on or fail
                        if (r_tmr == TMR_LAST) begin
                            r_res_status <= ST_NO_RESOURCE;
                            r_res_chan   <= '0;
                            r_res_tmr    <= '0;
                            r_state      <= S_DONE;
                        end else begin
                            r_tmr   <= r_tmr + TMR_W'(1);
                            r_state <= S_TIMER;
                        end
                    end else if (slot_ok) begin
                        r_busy[slot_ch[CH_IDX_W-1:0]] <= 1'b1;
                        r_cnt[r_tmr] <= r_cnt[r_tmr] + CNT_W'(1);
                        r_res_status <= ST_DONE;
                        r_res_chan   <= slot_ch[CH_W-1:0];
                        r_res_tmr    <= r_tmr;
                        r_state      <= S_DONE;
                    end else begin
                        r_slot <= r_slot + CNT_W'(1);
                    end
                end

                S_EXEC: begin
                    r_res_chan <= '0;
                    r_state    <= S_DONE;
                    unique case (r_func)
                        FN_RELEASE: begin
                            r_res_tmr <= rel_tmr;
                            if (!rel_in_range || !r_busy[rel_idx]) begin
                                r_res_status <= ST_NOT_BUSY;
                            end else begin
                                r_res_status   <= ST_DONE;
                                r_busy[rel_idx] <= 1'b0;
                                r_cnt[rel_tmr] <= rel_cnt;
                                if (rel_cnt == '0) begin
                                    r_tf_set[rel_tmr] <= 1'b0;
                                    r_tf[rel_tmr]     <= '0;
                                end
                            end
                        end
                        FN_RESERVE: begin
                            // First use fills every timer, then open the chosen one
                            if (!r_explicit) begin
                                r_explicit <= 1'b1;
                                for (int t = 0; t < TIMER_COUNT; t++) begin
                                    r_cnt[t] <= (TMR_W'(t) == r_tsel) ? '0 : r_limit;
                                end
                            end else begin
                                r_cnt[r_tsel] <= '0;
                            end
                            r_res_status  <= ST_DONE;
                            r_res_tmr     <= r_tsel;
                        end
                        default: begin
                            r_res_status <= ST_DONE;
                            r_res_tmr    <= '0;
                        end
                    endcase
                end

                S_DONE: begin
                    // Hold the result until the output register is free
                    if (out_load) begin
                        r_out_status <= r_res_status;
                        r_out_chan   <= r_res_chan;
                        r_out_tmr    <= r_res_tmr;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A granted channel is busy and sits on the granted timer
    a_grant_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_func == FN_ALLOC && r_res_status == ST_DONE)
        |-> r_busy[r_res_chan[CH_IDX_W-1:0]])
        else $error("granted channel not marked busy");

    a_grant_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_func == FN_ALLOC && r_res_status == ST_DONE)
        |-> (r_res_chan[2:1] == r_res_tmr))
        else $error("granted channel does not belong to granted timer");

    // Slot scan never runs past the limit
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SLOT) |-> (r_slot <= r_limit))
        else $error("slot scan ran past the limit");

    // An unset timer keeps a zero frequency
    a_freq_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_tf_set[r_tmr] |-> (r_tf[r_tmr] == '0))
        else $error("unset timer holds a frequency");

    // A successful release leaves the channel free
    a_release_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_func == FN_RELEASE && rel_in_range && r_busy[rel_idx])
        |=> !r_busy[rel_idx])
        else $error("released channel still busy");

endmodule
